### hw/rtl/s2ct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2ct_pkg
// Shared types and constants for the stage-2 context table.
// ----------------------------------------------------------------------------
package s2ct_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 16;
	localparam int unsigned KEY_W = 64;
	localparam int unsigned COUNT_W = 8;

	// item kinds
	localparam logic [1:0] KIND_ACQUIRE = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	// configuration register indexes
	localparam logic CFG_ENTRIES_IN_USE = 1'b0;
	localparam logic CFG_VMID_SIXTEEN = 1'b1;

	localparam logic [4:0] ENTRIES_RESET = 5'd2;

	localparam logic signed [COUNT_W-1:0] COUNT_UNUSED = -8'sd1;
	localparam logic signed [COUNT_W-1:0] COUNT_SAT = 8'sd127;
	localparam logic signed [COUNT_W-1:0] COUNT_ONE = 8'sd1;

	// write enables into the entry memory
	typedef struct packed {
		logic cnt;
		logic key;
	} mem_wen_t;

endpackage
`default_nettype wire

### hw/rtl/s2ct_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2ct_mem
// Entry storage: use counts and key/flag words, one read and one write port,
// registered read data.
// ----------------------------------------------------------------------------
module s2ct_mem #(
	parameter int unsigned DEPTH = s2ct_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic                                        clk,
	input  wire logic                                        rd_en,
	input  wire logic [AW-1:0]                               rd_addr,
	input  wire s2ct_pkg::mem_wen_t                          wen,
	input  wire logic [AW-1:0]                               wr_addr,
	input  wire logic signed [s2ct_pkg::COUNT_W-1:0]         wr_cnt,
	input  wire logic [s2ct_pkg::KEY_W-1:0]                  wr_key,
	input  wire logic                                        wr_flag,
	output logic signed [s2ct_pkg::COUNT_W-1:0]              rd_cnt,
	output logic [s2ct_pkg::KEY_W-1:0]                       rd_key,
	output logic                                             rd_flag
);

	logic signed [s2ct_pkg::COUNT_W-1:0] cnt_mem [DEPTH];
	logic [s2ct_pkg::KEY_W:0]            key_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen.cnt) begin
			cnt_mem[wr_addr] <= wr_cnt;
		end
		if (wen.key) begin
			key_mem[wr_addr] <= {wr_flag, wr_key};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_cnt <= cnt_mem[rd_addr];
			{rd_flag, rd_key} <= key_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/stage2_context_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stage2_context_table
// Reference-counted table of stage-2 translation contexts.
//
// Input channel (in_valid/in_ready) takes one request item: acquire, release
// or lookup. Output channel (out_valid/out_ready) returns exactly one result
// item per request. Config port (cfg_we/cfg_addr/cfg_wdata) sets the active
// entry count and VMID width; write it only while the block is idle.
//
// Acquire and lookup scan the active entries one per cycle through the
// single read port of the entry memory, then pass an update step and a
// finish step. Release reads one entry and decrements its count if above
// zero. Host-context acquires and releases and unknown kinds go straight
// to the finish step. One item is processed at a time; in_ready is high
// only while idle and returns the cycle after the result is registered,
// so no new item is taken before the last result is registered.
// A result waits in the output register until taken; the next item is
// accepted meanwhile but its result holds until the register frees up.
//
// Reset marks every entry unused (count of minus one) through per-entry
// valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stage2_context_table #(
	parameter int unsigned MAX_ENTRIES = s2ct_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [4:0]  cfg_wdata,
	// request
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [63:0] vttbr,
	input  wire logic        stage2_enabled,
	input  wire logic        in_hyp_context,
	input  wire logic [3:0]  entry_index,
	// result
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             hit,
	output logic             allocated,
	output logic             clear_needed,
	output logic             host_selected,
	output logic             error,
	output logic [3:0]       result_index
);

	localparam int unsigned IW = $clog2(MAX_ENTRIES);
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned KW = s2ct_pkg::KEY_W;
	localparam int unsigned NW = s2ct_pkg::COUNT_W;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SCAN    = 6'b000010,
		ST_UPDATE  = 6'b000100,
		ST_REL_RD  = 6'b001000,
		ST_REL_UPD = 6'b010000,
		ST_FINISH  = 6'b100000
	} state_t;

	state_t state_q;

	// config registers
	logic [4:0] entries_q;
	logic       vmid16_q;

	// captured request
	logic [1:0]    kind_q;
	logic [KW-1:0] key_q;
	logic          s2_q;
	logic [3:0]    idx_q;

	// scan
	logic [CW-1:0] rd_q;
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic          found_q;
	logic [IW-1:0] match_idx_q;
	logic signed [NW-1:0] match_cnt_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic          free_zero_q;

	logic [MAX_ENTRIES-1:0] valid_q;

	// pending result
	logic       res_hit_q, res_alloc_q, res_clr_q, res_host_q, res_err_q;
	logic [3:0] res_idx_q;

	// memory ports
	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	s2ct_pkg::mem_wen_t   wen;
	logic [IW-1:0]        wr_addr;
	logic signed [NW-1:0] wr_cnt;
	logic signed [NW-1:0] rd_cnt;
	logic [KW-1:0]        rd_key;
	logic                 rd_flag;

	logic [CW-1:0]        n_act;
	logic                 accept;
	logic [IW-1:0]        idx_addr;
	logic                 idx_in_range;
	logic signed [NW-1:0] ent_cnt;
	logic                 ent_live;
	logic                 ent_match;
	logic                 ent_free;
	logic [15:0]          vmid_diff;
	logic                 vmid_eq;
	logic signed [NW-1:0] rel_cnt;
	logic                 rel_ok;
	logic                 out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		if ({27'd0, entries_q} > 32'(MAX_ENTRIES)) begin
			n_act = CW'(MAX_ENTRIES);
		end else begin
			n_act = CW'(entries_q);
		end
	end

	assign idx_addr     = IW'(idx_q);
	assign idx_in_range = 32'(idx_q) < 32'(n_act);

	// entry compare, one entry per cycle from the memory read port
	always_comb begin
		ent_cnt   = valid_q[cmp_idx_s1] ? rd_cnt : s2ct_pkg::COUNT_UNUSED;
		ent_live  = !ent_cnt[NW-1];
		ent_free  = ent_cnt[NW-1] || (ent_cnt == '0);
		vmid_diff = key_q[63:48] ^ rd_key[63:48];
		vmid_eq   = vmid16_q ? (vmid_diff == '0) : (vmid_diff[7:0] == '0);
		if (s2_q) begin
			ent_match = ent_live && rd_flag && (rd_key == key_q);
		end else begin
			ent_match = ent_live && !rd_flag && vmid_eq;
		end
	end

	always_comb begin
		rel_cnt = (idx_in_range && valid_q[idx_addr]) ? rd_cnt : s2ct_pkg::COUNT_UNUSED;
		rel_ok  = idx_in_range && !rel_cnt[NW-1] && (rel_cnt != '0);
	end

	// memory access
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_q[IW-1:0];
		wen     = '0;
		wr_addr = match_idx_q;
		wr_cnt  = s2ct_pkg::COUNT_ONE;
		unique case (state_q)
			ST_SCAN: begin
				rd_en = (rd_q != n_act);
			end
			ST_REL_RD: begin
				rd_en   = idx_in_range;
				rd_addr = idx_addr;
			end
			ST_UPDATE: begin
				if (kind_q == s2ct_pkg::KIND_ACQUIRE) begin
					if (found_q) begin
						wen.cnt = 1'b1;
						wr_cnt  = (match_cnt_q == s2ct_pkg::COUNT_SAT) ?
							s2ct_pkg::COUNT_SAT : match_cnt_q + s2ct_pkg::COUNT_ONE;
					end else if (free_found_q) begin
						wen.cnt = 1'b1;
						wen.key = 1'b1;
						wr_addr = free_idx_q;
					end
				end
			end
			ST_REL_UPD: begin
				wen.cnt = rel_ok;
				wr_addr = idx_addr;
				wr_cnt  = rel_cnt - s2ct_pkg::COUNT_ONE;
			end
			ST_IDLE, ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	s2ct_mem #(
		.DEPTH (MAX_ENTRIES),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wen     (wen),
		.wr_addr (wr_addr),
		.wr_cnt  (wr_cnt),
		.wr_key  (key_q),
		.wr_flag (s2_q),
		.rd_cnt  (rd_cnt),
		.rd_key  (rd_key),
		.rd_flag (rd_flag)
	);

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= s2ct_pkg::ENTRIES_RESET;
			vmid16_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				s2ct_pkg::CFG_ENTRIES_IN_USE: entries_q <= cfg_wdata;
				s2ct_pkg::CFG_VMID_SIXTEEN:   vmid16_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			key_q  <= {vttbr[63:1], 1'b0};
			s2_q   <= stage2_enabled;
			idx_q  <= entry_index;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_q         <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			found_q      <= 1'b0;
			match_idx_q  <= '0;
			match_cnt_q  <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			free_zero_q  <= 1'b0;
			valid_q      <= '0;
			res_hit_q    <= 1'b0;
			res_alloc_q  <= 1'b0;
			res_clr_q    <= 1'b0;
			res_host_q   <= 1'b0;
			res_err_q    <= 1'b0;
			res_idx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_q         <= '0;
						cmp_vld_s1   <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						free_zero_q  <= 1'b0;
						res_hit_q    <= 1'b0;
						res_alloc_q  <= 1'b0;
						res_clr_q    <= 1'b0;
						res_host_q   <= 1'b0;
						res_err_q    <= 1'b0;
						res_idx_q    <= '0;
						priority if (kind == s2ct_pkg::KIND_LOOKUP) begin
							state_q <= ST_SCAN;
						end else if ((kind == s2ct_pkg::KIND_ACQUIRE ||
						              kind == s2ct_pkg::KIND_RELEASE) && in_hyp_context) begin
							res_host_q <= 1'b1;
							state_q    <= ST_FINISH;
						end else if (kind == s2ct_pkg::KIND_ACQUIRE) begin
							state_q <= ST_SCAN;
						end else if (kind == s2ct_pkg::KIND_RELEASE) begin
							state_q <= ST_REL_RD;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (rd_q != n_act) begin
						rd_q       <= rd_q + CW'(1);
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= rd_q[IW-1:0];
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					if (cmp_vld_s1) begin
						if (ent_match && !found_q) begin
							found_q     <= 1'b1;
							match_idx_q <= cmp_idx_s1;
							match_cnt_q <= ent_cnt;
						end
						if (ent_free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= cmp_idx_s1;
							free_zero_q  <= !ent_cnt[NW-1];
						end
					end
					if (rd_q == n_act && !cmp_vld_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (found_q) begin
						res_hit_q <= 1'b1;
						res_idx_q <= 4'(match_idx_q);
					end else if (kind_q == s2ct_pkg::KIND_ACQUIRE) begin
						if (free_found_q) begin
							res_alloc_q         <= 1'b1;
							res_clr_q           <= free_zero_q;
							res_idx_q           <= 4'(free_idx_q);
							valid_q[free_idx_q] <= 1'b1;
						end else begin
							res_err_q <= 1'b1;
						end
					end
					state_q <= ST_FINISH;
				end
				ST_REL_RD: begin
					state_q <= ST_REL_UPD;
				end
				ST_REL_UPD: begin
					res_idx_q <= idx_q;
					res_err_q <= !rel_ok;
					state_q   <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			hit           <= res_hit_q;
			allocated     <= res_alloc_q;
			clear_needed  <= res_clr_q;
			host_selected <= res_host_q;
			error         <= res_err_q;
			result_index  <= res_idx_q;
		end
	end

endmodule
`default_nettype wire
